// ----- rtl/core/pwg_pkg.sv -----
// ----------------------------------------------------------------------------
// pwg_pkg
// Shared types and constants of the pulse waveform generator.
// ----------------------------------------------------------------------------
package pwg_pkg;

   localparam int LEVEL_BITS          = 24;
   localparam int QUERY_BITS          = 48;
   localparam int STEP_BITS           = 32;
   localparam int CYCLE_BITS          = 16;
   localparam int CSR_DATA_BITS       = 48;
   localparam int CSR_INDEX_BITS      = 3;
   localparam int TIME_BITS_DEFAULT   = 32;
   localparam int FIFO_DEPTH_DEFAULT  = 4;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BASE_LEVEL   = 3'd0,
      CSR_PULSE_LEVEL  = 3'd1,
      CSR_START_DELAY  = 3'd2,
      CSR_RISE_TICKS   = 3'd3,
      CSR_FALL_TICKS   = 3'd4,
      CSR_HIGH_TICKS   = 3'd5,
      CSR_PERIOD_TICKS = 3'd6,
      CSR_CYCLE_LIMIT  = 3'd7
   } csr_index_type;

   // before delay, zero-period fault, running waveform
   typedef enum logic [1:0] {
      KIND_BASE  = 2'd0,
      KIND_FAULT = 2'd1,
      KIND_RUN   = 2'd2
   } item_kind_type;

   typedef struct packed {
      logic [QUERY_BITS-1:0] query_time;
      logic [STEP_BITS-1:0]  step_ticks;
   } req_type;

   typedef struct packed {
      logic signed [LEVEL_BITS-1:0] level;
      logic                         config_error;
   } rsp_type;

endpackage

// ----- rtl/core/pwg_fifo.sv -----
// ----------------------------------------------------------------------------
// pwg_fifo
// Small queue between the classifying front end and the waveform back end.
// ----------------------------------------------------------------------------
module pwg_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = pwg_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             push_data,
   input  logic                         pop,
   output logic [WIDTH-1:0]             pop_data,
   output logic [$clog2(DEPTH+1)-1:0]   count,
   output logic                         empty
);
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH+1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign do_pop  = pop && (count_ff != '0);
   assign do_push = push && ((count_ff != CNT_BITS'(DEPTH)) || do_pop);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign count    = count_ff;
   assign empty    = (count_ff == '0);

endmodule

// ----- rtl/core/pwg_front.sv -----
// ----------------------------------------------------------------------------
// pwg_front
// Takes requests, resolves ramp lengths, classifies against the start delay
// and period, clamps the elapsed time to the last cycle, and queues the item.
// ----------------------------------------------------------------------------
module pwg_front #(
   parameter int TIME_BITS  = pwg_pkg::TIME_BITS_DEFAULT,
   parameter int FIFO_DEPTH = pwg_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  pwg_pkg::req_type                    req_data,
   input  logic [TIME_BITS-1:0]                start_delay,
   input  logic [TIME_BITS-1:0]                rise_ticks,
   input  logic [TIME_BITS-1:0]                fall_ticks,
   input  logic [TIME_BITS-1:0]                period_ticks,
   input  logic [pwg_pkg::CYCLE_BITS-1:0]      cycle_limit,
   input  logic [$clog2(FIFO_DEPTH+1)-1:0]     fifo_count,
   output logic                                push,
   output pwg_pkg::item_kind_type              push_kind,
   output logic [pwg_pkg::QUERY_BITS-1:0]      push_dist,
   output logic [TIME_BITS-1:0]                push_rise,
   output logic [TIME_BITS-1:0]                push_fall
);
   import pwg_pkg::*;

   localparam int CNT_BITS  = $clog2(FIFO_DEPTH+1);
   localparam int SPAN_BITS = TIME_BITS + CYCLE_BITS;
   localparam int CMP_BITS  = (QUERY_BITS > SPAN_BITS) ? QUERY_BITS : SPAN_BITS;

   logic                   accept;
   logic [CNT_BITS:0]      credits;

   logic                   s0_valid_ff;
   req_type                s0_req_ff;

   logic                   a_valid_ff;
   item_kind_type          a_kind_ff, a_kind_in;
   logic [QUERY_BITS-1:0]  a_dist_ff, a_dist_in;
   logic [TIME_BITS-1:0]   a_rise_ff, a_rise_in;
   logic [TIME_BITS-1:0]   a_fall_ff, a_fall_in;
   logic [TIME_BITS-1:0]   step_eff;

   logic [SPAN_BITS-1:0]   span_ff, span_in;

   assign credits = (CNT_BITS+1)'(fifo_count) + (CNT_BITS+1)'(s0_valid_ff)
                  + (CNT_BITS+1)'(a_valid_ff);
   assign busy    = reset || (credits >= (CNT_BITS+1)'(FIFO_DEPTH));
   assign accept  = start && !busy;

   assign span_in  = SPAN_BITS'(period_ticks) * SPAN_BITS'(cycle_limit);
   assign step_eff = TIME_BITS'(s0_req_ff.step_ticks);

   always_comb begin
      a_dist_in = s0_req_ff.query_time - QUERY_BITS'(start_delay);
      a_rise_in = (rise_ticks != '0) ? rise_ticks : step_eff;
      a_fall_in = (fall_ticks != '0) ? fall_ticks : step_eff;
      priority if (s0_req_ff.query_time < QUERY_BITS'(start_delay)) begin
         a_kind_in = KIND_BASE;
      end else if (period_ticks == '0) begin
         a_kind_in = KIND_FAULT;
      end else begin
         a_kind_in = KIND_RUN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         a_valid_ff  <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
         a_valid_ff  <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_req_ff <= req_data;
      end
      a_kind_ff <= a_kind_in;
      a_dist_ff <= a_dist_in;
      a_rise_ff <= a_rise_in;
      a_fall_ff <= a_fall_in;
      span_ff   <= span_in;
   end

   // freeze at the end of the last cycle
   assign push_dist = (CMP_BITS'(a_dist_ff) > CMP_BITS'(span_ff)) ?
                      QUERY_BITS'(span_ff) : a_dist_ff;
   assign push      = a_valid_ff;
   assign push_kind = a_kind_ff;
   assign push_rise = a_rise_ff;
   assign push_fall = a_fall_ff;

endmodule

// ----- rtl/core/pwg_phase.sv -----
// ----------------------------------------------------------------------------
// pwg_phase
// Pipelined restoring remainder: phase = elapsed time modulo the period,
// one dividend bit per stage.
// ----------------------------------------------------------------------------
module pwg_phase #(
   parameter int TIME_BITS = pwg_pkg::TIME_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  pwg_pkg::item_kind_type          in_kind,
   input  logic [pwg_pkg::QUERY_BITS-1:0]  in_dist,
   input  logic [TIME_BITS-1:0]            in_rise,
   input  logic [TIME_BITS-1:0]            in_fall,
   input  logic [TIME_BITS-1:0]            period_ticks,
   output logic                            out_valid,
   output pwg_pkg::item_kind_type          out_kind,
   output logic [TIME_BITS-1:0]            out_phase,
   output logic [TIME_BITS-1:0]            out_rise,
   output logic [TIME_BITS-1:0]            out_fall
);
   import pwg_pkg::*;

   localparam int NSTG = QUERY_BITS;

   logic [NSTG:0]           valid_ff;
   item_kind_type           kind_ff [0:NSTG];
   logic [TIME_BITS-1:0]    rem_ff  [0:NSTG];
   logic [QUERY_BITS-1:0]   dvd_ff  [0:NSTG];
   logic [TIME_BITS-1:0]    rise_ff [0:NSTG];
   logic [TIME_BITS-1:0]    fall_ff [0:NSTG];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[NSTG-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      kind_ff[0] <= in_kind;
      rem_ff[0]  <= '0;
      dvd_ff[0]  <= in_dist;
      rise_ff[0] <= in_rise;
      fall_ff[0] <= in_fall;
   end

   for (genvar g = 0; g < NSTG; g++) begin : g_stage
      logic [TIME_BITS:0] part;
      logic [TIME_BITS:0] diff;
      logic [TIME_BITS-1:0] rem_in;

      assign part   = {rem_ff[g], dvd_ff[g][QUERY_BITS-1]};
      assign diff   = part - {1'b0, period_ticks};
      assign rem_in = (part >= {1'b0, period_ticks}) ? diff[TIME_BITS-1:0]
                                                     : part[TIME_BITS-1:0];

      always_ff @(posedge clock) begin
         kind_ff[g+1] <= kind_ff[g];
         rem_ff[g+1]  <= rem_in;
         dvd_ff[g+1]  <= {dvd_ff[g][QUERY_BITS-2:0], 1'b0};
         rise_ff[g+1] <= rise_ff[g];
         fall_ff[g+1] <= fall_ff[g];
      end
   end

   assign out_valid = valid_ff[NSTG];
   assign out_kind  = kind_ff[NSTG];
   assign out_phase = rem_ff[NSTG];
   assign out_rise  = rise_ff[NSTG];
   assign out_fall  = fall_ff[NSTG];

endmodule

// ----- rtl/core/pwg_ramp.sv -----
// ----------------------------------------------------------------------------
// pwg_ramp
// Picks the waveform segment from the phase, then scales the level step by
// elapsed/duration in a pipelined multiply-divide, one level bit per stage.
// ----------------------------------------------------------------------------
module pwg_ramp #(
   parameter int TIME_BITS = pwg_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  pwg_pkg::item_kind_type                in_kind,
   input  logic [TIME_BITS-1:0]                  in_phase,
   input  logic [TIME_BITS-1:0]                  in_rise,
   input  logic [TIME_BITS-1:0]                  in_fall,
   input  logic [TIME_BITS-1:0]                  high_ticks,
   input  logic signed [pwg_pkg::LEVEL_BITS-1:0] base_level,
   input  logic signed [pwg_pkg::LEVEL_BITS-1:0] pulse_level,
   output logic                                  rsp_valid,
   output pwg_pkg::rsp_type                      rsp_data
);
   import pwg_pkg::*;

   localparam int LB = LEVEL_BITS;

   // segment select
   logic signed [LB:0]    delta;
   logic                  rise_down;
   logic [LB:0]           delta_abs;
   logic [TIME_BITS:0]    end_high;
   logic [TIME_BITS+1:0]  end_fall;

   logic                  c_ramp_in, c_down_in, c_err_in;
   logic [LB-1:0]         c_from_in;
   logic [TIME_BITS-1:0]  c_num_in, c_den_in;

   // multiply-divide pipeline, stage 0 holds the segment decision
   logic [LB:0]           valid_ff;
   logic                  ramp_ff [0:LB];
   logic                  down_ff [0:LB];
   logic                  err_ff  [0:LB];
   logic [LB-1:0]         from_ff [0:LB];
   logic [LB-1:0]         mag_ff  [0:LB];
   logic [LB-1:0]         quo_ff  [0:LB];
   logic [TIME_BITS-1:0]  rem_ff  [0:LB];
   logic [TIME_BITS-1:0]  num_ff  [0:LB];
   logic [TIME_BITS-1:0]  den_ff  [0:LB];

   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff, rsp_data_in;

   assign delta     = {pulse_level[LB-1], pulse_level} - {base_level[LB-1], base_level};
   assign rise_down = delta[LB];
   assign delta_abs = rise_down ? -delta : delta;
   assign end_high  = (TIME_BITS+1)'(in_rise) + (TIME_BITS+1)'(high_ticks);
   assign end_fall  = (TIME_BITS+2)'(end_high) + (TIME_BITS+2)'(in_fall);

   always_comb begin
      c_ramp_in = 1'b0;
      c_down_in = rise_down;
      c_err_in  = 1'b0;
      c_from_in = base_level;
      c_num_in  = in_phase;
      c_den_in  = in_rise;
      unique case (in_kind)
         KIND_BASE: begin
         end
         KIND_FAULT: begin
            c_err_in = 1'b1;
         end
         KIND_RUN: begin
            priority if (in_phase < in_rise) begin
               c_ramp_in = 1'b1;
            end else if ((TIME_BITS+1)'(in_phase) < end_high) begin
               c_from_in = pulse_level;
            end else if ((TIME_BITS+2)'(in_phase) < end_fall) begin
               c_ramp_in = 1'b1;
               c_down_in = !rise_down;
               c_from_in = pulse_level;
               c_num_in  = in_phase - end_high[TIME_BITS-1:0];
               c_den_in  = in_fall;
            end else begin
               c_from_in = base_level;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= {valid_ff[LB-1:0], in_valid};
         rsp_valid_ff <= valid_ff[LB];
      end
   end

   always_ff @(posedge clock) begin
      ramp_ff[0] <= c_ramp_in;
      down_ff[0] <= c_down_in;
      err_ff[0]  <= c_err_in;
      from_ff[0] <= c_from_in;
      mag_ff[0]  <= delta_abs[LB-1:0];
      quo_ff[0]  <= '0;
      rem_ff[0]  <= '0;
      num_ff[0]  <= c_num_in;
      den_ff[0]  <= c_den_in;
   end

   // remainder stays below the divisor, so each digit is 0, 1 or 2
   for (genvar g = 0; g < LB; g++) begin : g_stage
      logic [TIME_BITS+1:0] acc;
      logic [TIME_BITS+1:0] den1, den2;
      logic [TIME_BITS+1:0] rem_in;
      logic [1:0]           digit;

      assign den1 = (TIME_BITS+2)'(den_ff[g]);
      assign den2 = {1'b0, den_ff[g], 1'b0};
      assign acc  = {1'b0, rem_ff[g], 1'b0}
                  + (mag_ff[g][LB-1] ? (TIME_BITS+2)'(num_ff[g]) : '0);

      always_comb begin
         priority if (acc >= den2) begin
            rem_in = acc - den2;
            digit  = 2'd2;
         end else if (acc >= den1) begin
            rem_in = acc - den1;
            digit  = 2'd1;
         end else begin
            rem_in = acc;
            digit  = 2'd0;
         end
      end

      always_ff @(posedge clock) begin
         ramp_ff[g+1] <= ramp_ff[g];
         down_ff[g+1] <= down_ff[g];
         err_ff[g+1]  <= err_ff[g];
         from_ff[g+1] <= from_ff[g];
         mag_ff[g+1]  <= {mag_ff[g][LB-2:0], 1'b0};
         quo_ff[g+1]  <= {quo_ff[g][LB-2:0], 1'b0} + LB'(digit);
         rem_ff[g+1]  <= rem_in[TIME_BITS-1:0];
         num_ff[g+1]  <= num_ff[g];
         den_ff[g+1]  <= den_ff[g];
      end
   end

   always_comb begin
      rsp_data_in.config_error = err_ff[LB];
      if (!ramp_ff[LB]) begin
         rsp_data_in.level = from_ff[LB];
      end else if (down_ff[LB]) begin
         rsp_data_in.level = from_ff[LB] - quo_ff[LB];
      end else begin
         rsp_data_in.level = from_ff[LB] + quo_ff[LB];
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/core/pulse_waveform_generator.sv -----
// ----------------------------------------------------------------------------
// pulse_waveform_generator
// Periodic trapezoid pulse source evaluated at requested time points.
// ----------------------------------------------------------------------------
// Request: drive req_data (query_time, step_ticks) with start; the request is
// taken at a clock edge where start is high and busy is low. A new request
// may be taken on every cycle.
// Response: rsp_valid strobes for one cycle with rsp_data (level,
// config_error). With the default package widths the path holds 78 registers,
// the first loaded at the taking edge: two front stages, one queue stage, a
// 49-stage phase remainder pipeline (load plus one stage per dividend bit),
// one segment select stage, a 24-stage ramp multiply-divide and the output
// register.
// Responses leave in request order, one per request, and cannot be held off.
// Throughput: one request per clock while busy is low, set by the
// bit-per-stage remainder and multiply-divide pipelines.
// Configuration: csr_valid/csr_ready with csr_index and csr_wdata, written
// only while no request is in flight; the user must keep to this, as the
// block itself does not enforce it. csr_ready is high outside reset.
// Reset: synchronous, drops all requests in flight and restores the
// register defaults (period and cycle limit one, everything else zero).
// ----------------------------------------------------------------------------
module pulse_waveform_generator #(
   parameter int TIME_BITS  = pwg_pkg::TIME_BITS_DEFAULT,
   parameter int FIFO_DEPTH = pwg_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  pwg_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   output pwg_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  pwg_pkg::csr_index_type              csr_index,
   input  logic [pwg_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import pwg_pkg::*;

   localparam int CNT_BITS = $clog2(FIFO_DEPTH+1);

   typedef struct packed {
      item_kind_type          kind;
      logic [QUERY_BITS-1:0]  elapsed;
      logic [TIME_BITS-1:0]   rise;
      logic [TIME_BITS-1:0]   fall;
   } entry_type;

   logic signed [LEVEL_BITS-1:0] base_level_ff, pulse_level_ff;
   logic [TIME_BITS-1:0]         start_delay_ff, rise_ticks_ff, fall_ticks_ff;
   logic [TIME_BITS-1:0]         high_ticks_ff, period_ticks_ff;
   logic [CYCLE_BITS-1:0]        cycle_limit_ff;
   logic                         csr_write;

   logic                   fifo_push, fifo_empty;
   logic [CNT_BITS-1:0]    fifo_count;
   entry_type              fifo_wr, fifo_rd;
   item_kind_type          front_kind;
   logic [QUERY_BITS-1:0]  front_dist;
   logic [TIME_BITS-1:0]   front_rise, front_fall;

   logic                   ph_valid;
   item_kind_type          ph_kind;
   logic [TIME_BITS-1:0]   ph_phase, ph_rise, ph_fall;

   assign csr_ready = !reset;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_level_ff   <= '0;
         pulse_level_ff  <= '0;
         start_delay_ff  <= '0;
         rise_ticks_ff   <= '0;
         fall_ticks_ff   <= '0;
         high_ticks_ff   <= '0;
         period_ticks_ff <= TIME_BITS'(1);
         cycle_limit_ff  <= CYCLE_BITS'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BASE_LEVEL:   base_level_ff   <= csr_wdata[LEVEL_BITS-1:0];
            CSR_PULSE_LEVEL:  pulse_level_ff  <= csr_wdata[LEVEL_BITS-1:0];
            CSR_START_DELAY:  start_delay_ff  <= csr_wdata[TIME_BITS-1:0];
            CSR_RISE_TICKS:   rise_ticks_ff   <= csr_wdata[TIME_BITS-1:0];
            CSR_FALL_TICKS:   fall_ticks_ff   <= csr_wdata[TIME_BITS-1:0];
            CSR_HIGH_TICKS:   high_ticks_ff   <= csr_wdata[TIME_BITS-1:0];
            CSR_PERIOD_TICKS: period_ticks_ff <= csr_wdata[TIME_BITS-1:0];
            CSR_CYCLE_LIMIT:  cycle_limit_ff  <= csr_wdata[CYCLE_BITS-1:0];
         endcase
      end
   end

   pwg_front #(
      .TIME_BITS  (TIME_BITS),
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .start_delay  (start_delay_ff),
      .rise_ticks   (rise_ticks_ff),
      .fall_ticks   (fall_ticks_ff),
      .period_ticks (period_ticks_ff),
      .cycle_limit  (cycle_limit_ff),
      .fifo_count   (fifo_count),
      .push         (fifo_push),
      .push_kind    (front_kind),
      .push_dist    (front_dist),
      .push_rise    (front_rise),
      .push_fall    (front_fall)
   );

   assign fifo_wr = '{kind: front_kind, elapsed: front_dist, rise: front_rise,
                      fall: front_fall};

   pwg_fifo #(
      .WIDTH (($bits(entry_type))),
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (fifo_wr),
      .pop       (!fifo_empty),
      .pop_data  (fifo_rd),
      .count     (fifo_count),
      .empty     (fifo_empty)
   );

   pwg_phase #(
      .TIME_BITS (TIME_BITS)
   ) u_phase (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (!fifo_empty),
      .in_kind      (fifo_rd.kind),
      .in_dist      (fifo_rd.elapsed),
      .in_rise      (fifo_rd.rise),
      .in_fall      (fifo_rd.fall),
      .period_ticks (period_ticks_ff),
      .out_valid    (ph_valid),
      .out_kind     (ph_kind),
      .out_phase    (ph_phase),
      .out_rise     (ph_rise),
      .out_fall     (ph_fall)
   );

   pwg_ramp #(
      .TIME_BITS (TIME_BITS)
   ) u_ramp (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (ph_valid),
      .in_kind     (ph_kind),
      .in_phase    (ph_phase),
      .in_rise     (ph_rise),
      .in_fall     (ph_fall),
      .high_ticks  (high_ticks_ff),
      .base_level  (base_level_ff),
      .pulse_level (pulse_level_ff),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   a_fifo_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fifo_push |-> (fifo_count < CNT_BITS'(FIFO_DEPTH)))
      else $error("queue push while full");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid && fifo_empty))
      else $error("response or queued item right after reset");

endmodule
